[hdl/patch_record_applier_macros.svh]
`ifndef PATCH_RECORD_APPLIER_MACROS_SVH
`define PATCH_RECORD_APPLIER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("patch record applier check failed");

// Next-cycle implication, disabled while reset is high.
`define PRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("patch record applier check failed");

// Checks what the cycle after a reset edge shows.
`define PRC_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("patch record applier check failed");

`endif

[hdl/prc_pkg.sv]
`default_nettype none

package prc_pkg;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_DEFER  = 2'd1,
      KIND_REPORT = 2'd2
   } prc_kind_type;

   typedef enum logic [2:0] {
      RPT_APPLIED      = 3'd0,
      RPT_CHANGES_CODE = 3'd1,
      RPT_DEFERRED     = 3'd2,
      RPT_LOAD_CODE    = 3'd3,
      RPT_NEEDS_FIXED  = 3'd4,
      RPT_OUTSIDE      = 3'd5,
      RPT_OVERRUN      = 3'd6,
      RPT_END          = 3'd7
   } prc_code_type;

   typedef enum logic [2:0] {
      MODE_SKIP  = 3'b001,
      MODE_IMAGE = 3'b010,
      MODE_DEFER = 3'b100
   } prc_mode_type;

   localparam logic [2:0] CSR_OVERLAY_PRESENT  = 3'd0;
   localparam logic [2:0] CSR_OVERLAY_BASE     = 3'd1;
   localparam logic [2:0] CSR_OVERLAY_CODE_END = 3'd2;
   localparam logic [2:0] CSR_IMAGE_SIZE       = 3'd3;
   localparam logic [2:0] CSR_PATCH_SIZE       = 3'd4;

   localparam logic [31:0] END_MARKER  = 32'hFFFF_FFFF;
   localparam logic [31:0] MIRROR_MASK = 32'h3FFF_FFFF;
   localparam logic [31:0] RAM_START   = 32'h0800_0000;
   localparam logic [31:0] RAM_END     = 32'h0C00_0000;
   localparam logic [2:0]  HEADER_LAST = 3'd7;
   localparam int          LOAD_CODE_BIT = 31;

   typedef struct packed {
      logic        overlay_present;
      logic [31:0] overlay_base;
      logic [31:0] overlay_code_end;
      logic [31:0] image_size;
      logic [31:0] patch_size;
   } prc_cfg_type;

   typedef struct packed {
      prc_kind_type result_kind;
      logic [31:0]  target;
      logic [7:0]   data_byte;
      prc_code_type report_code;
      logic [30:0]  block_length;
      logic [31:0]  applied_total;
   } prc_result_type;

endpackage

`default_nettype wire

[hdl/prc_channels.sv]
`default_nettype none

interface prc_byte_chan;
   logic       valid;
   logic       ready;
   logic [7:0] patch_byte;

   modport source (output valid, output patch_byte, input ready);
   modport sink (input valid, input patch_byte, output ready);
endinterface

interface prc_result_chan;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] target;
   logic [7:0]  data_byte;
   logic [2:0]  report_code;
   logic [30:0] block_length;
   logic [31:0] applied_total;

   modport source (output valid, output result_kind, output target, output data_byte,
                   output report_code, output block_length, output applied_total,
                   input ready);
   modport sink (input valid, input result_kind, input target, input data_byte,
                 input report_code, input block_length, input applied_total,
                 output ready);
endinterface

interface prc_csr_chan;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/patch_record_applier.sv]
// Patch record applier: takes a patch stream one byte per cycle and emits at
// most one result per byte, either an image byte write, a deferred byte with
// its guest address, or one report per completed 8-byte record header. A byte
// passes an input register, the record decode and classification logic, and
// a result register, where the result is held until it is taken; the block
// takes a new byte every cycle as long as the result register is empty or is
// being emptied, so the sustained rate is one byte per cycle and is set only
// by how fast results are taken. Configuration writes must be made while no
// byte is in flight. After an end marker or an overrun report every further
// byte is taken and dropped until reset.
`default_nettype none

module patch_record_applier (
   input  wire logic        clock,
   input  wire logic        reset,
   prc_byte_chan.sink       req_if,
   prc_result_chan.source   rsp_if,
   prc_csr_chan.sink        csr_if
);
   import prc_pkg::*;

   prc_cfg_type    cfg;
   prc_result_type res;
   logic           res_valid;
   logic           byte_valid;
   logic [7:0]     byte_value;
   logic           can_accept;
   logic           fire;

   assign fire = byte_valid && can_accept;

   prc_csr_bank u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   prc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (fire),
      .byte_valid (byte_valid),
      .byte_value (byte_value)
   );

   prc_record_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .patch_byte (byte_value),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   prc_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .res_valid  (res_valid),
      .res        (res),
      .can_accept (can_accept),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

[hdl/prc_csr_bank.sv]
`default_nettype none

module prc_csr_bank (
   input  wire logic           clock,
   input  wire logic           reset,
   prc_csr_chan.sink           csr_if,
   output prc_pkg::prc_cfg_type cfg
);
   import prc_pkg::*;

   prc_cfg_type cfg_ff;
   prc_cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_OVERLAY_PRESENT:  cfg_in.overlay_present = csr_if.data[0];
            CSR_OVERLAY_BASE:     cfg_in.overlay_base = csr_if.data;
            CSR_OVERLAY_CODE_END: cfg_in.overlay_code_end = csr_if.data;
            CSR_IMAGE_SIZE:       cfg_in.image_size = csr_if.data;
            CSR_PATCH_SIZE:       cfg_in.patch_size = csr_if.data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hdl/prc_input_stage.sv]
`default_nettype none

module prc_input_stage (
   input  wire logic  clock,
   input  wire logic  reset,
   prc_byte_chan.sink req_if,
   input  wire logic  advance,
   output logic       byte_valid,
   output logic [7:0] byte_value
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // The register refills in the same cycle it hands its byte on.
   assign req_if.ready = !valid_ff || advance;
   assign take = req_if.valid && req_if.ready;
   assign byte_valid = valid_ff;
   assign byte_value = byte_ff;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_if.patch_byte;
      end
   end

endmodule

`default_nettype wire

[hdl/prc_record_engine.sv]
`default_nettype none

module prc_record_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [7:0]        patch_byte,
   input  wire prc_pkg::prc_cfg_type cfg,
   output logic                   res_valid,
   output prc_pkg::prc_result_type res
);
   import prc_pkg::*;

   logic [2:0]   header_index_ff, header_index_in;
   logic [31:0]  record_address_ff, record_address_in;
   logic [31:0]  record_length_ff, record_length_in;
   logic [30:0]  payload_left_ff, payload_left_in;
   logic [31:0]  stream_position_ff, stream_position_in;
   logic [31:0]  write_pointer_ff, write_pointer_in;
   prc_mode_type payload_mode_ff, payload_mode_in;
   logic         stopped_ff, stopped_in;
   logic [31:0]  applied_count_ff, applied_count_in;

   logic [31:0] addr_new;
   logic [31:0] lenw_new;
   logic [30:0] length;
   logic [31:0] guest;
   logic [31:0] guest_off;
   logic [31:0] pos_next;
   logic        in_ram;
   logic        active;
   logic        overrun;
   logic        overlay_fit;
   logic        raw_fit;

   // Merge the incoming header byte into the address or length word.
   always_comb begin
      addr_new = record_address_ff;
      lenw_new = record_length_ff;
      if (!header_index_ff[2]) begin
         addr_new[{header_index_ff[1:0], 3'b000} +: 8] = patch_byte;
      end else begin
         lenw_new[{header_index_ff[1:0], 3'b000} +: 8] = patch_byte;
      end
   end

   assign length    = lenw_new[30:0];
   assign guest     = addr_new & MIRROR_MASK;
   assign guest_off = guest - cfg.overlay_base;
   assign in_ram    = (guest >= RAM_START) && (guest < RAM_END);
   assign pos_next  = stream_position_ff + 32'd1;
   assign active    = !stopped_ff && (stream_position_ff < cfg.patch_size);

   assign overrun = ({1'b0, pos_next} + {2'b00, length}) > {1'b0, cfg.patch_size};
   assign overlay_fit = cfg.overlay_present && in_ram && (guest >= cfg.overlay_base) &&
                        (({1'b0, guest_off} + {2'b00, length}) <= {1'b0, cfg.image_size});
   assign raw_fit = !in_ram &&
                    (({1'b0, addr_new} + {2'b00, length}) <= {1'b0, cfg.image_size});

   always_comb begin
      header_index_in    = header_index_ff;
      record_address_in  = record_address_ff;
      record_length_in   = record_length_ff;
      payload_left_in    = payload_left_ff;
      stream_position_in = stream_position_ff;
      write_pointer_in   = write_pointer_ff;
      payload_mode_in    = payload_mode_ff;
      stopped_in         = stopped_ff;
      applied_count_in   = applied_count_ff;

      res_valid         = 1'b0;
      res.result_kind   = KIND_WRITE;
      res.target        = write_pointer_ff;
      res.data_byte     = patch_byte;
      res.report_code   = RPT_APPLIED;
      res.block_length  = '0;
      res.applied_total = applied_count_ff;

      if (fire && active) begin
         stream_position_in = pos_next;
         if (payload_left_ff != '0) begin
            payload_left_in  = payload_left_ff - 31'd1;
            write_pointer_in = write_pointer_ff + 32'd1;
            if (payload_mode_ff == MODE_IMAGE) begin
               res_valid = 1'b1;
               res.result_kind = KIND_WRITE;
            end else if (payload_mode_ff == MODE_DEFER) begin
               res_valid = 1'b1;
               res.result_kind = KIND_DEFER;
            end
            if (payload_left_ff == 31'd1) begin
               payload_mode_in = MODE_SKIP;
            end
         end else begin
            header_index_in   = header_index_ff + 3'd1;
            record_address_in = addr_new;
            record_length_in  = lenw_new;
            if (header_index_ff == HEADER_LAST) begin
               res_valid        = 1'b1;
               res.result_kind  = KIND_REPORT;
               res.target       = addr_new;
               res.data_byte    = '0;
               res.block_length = length;
               if (addr_new == END_MARKER) begin
                  stopped_in = 1'b1;
                  res.report_code = RPT_END;
               end else if (overrun) begin
                  stopped_in = 1'b1;
                  res.report_code = RPT_OVERRUN;
               end else begin
                  payload_left_in = length;
                  payload_mode_in = MODE_SKIP;
                  if (lenw_new[LOAD_CODE_BIT]) begin
                     res.report_code = RPT_LOAD_CODE;
                  end else if (overlay_fit) begin
                     payload_mode_in   = MODE_IMAGE;
                     write_pointer_in  = guest_off;
                     applied_count_in  = applied_count_ff + 32'd1;
                     res.applied_total = applied_count_ff + 32'd1;
                     res.report_code   = (guest < cfg.overlay_code_end) ?
                                         RPT_CHANGES_CODE : RPT_APPLIED;
                  end else if (cfg.overlay_present && in_ram) begin
                     payload_mode_in = MODE_DEFER;
                     write_pointer_in = guest;
                     res.report_code = RPT_DEFERRED;
                  end else if (raw_fit) begin
                     payload_mode_in   = MODE_IMAGE;
                     write_pointer_in  = addr_new;
                     applied_count_in  = applied_count_ff + 32'd1;
                     res.applied_total = applied_count_ff + 32'd1;
                     res.report_code   = RPT_APPLIED;
                  end else if (in_ram) begin
                     res.report_code = RPT_NEEDS_FIXED;
                  end else begin
                     res.report_code = RPT_OUTSIDE;
                  end
                  // An empty record carries nothing after its report.
                  if (length == '0) begin
                     payload_mode_in = MODE_SKIP;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff    <= '0;
         record_address_ff  <= '0;
         record_length_ff   <= '0;
         payload_left_ff    <= '0;
         stream_position_ff <= '0;
         write_pointer_ff   <= '0;
         payload_mode_ff    <= MODE_SKIP;
         stopped_ff         <= 1'b0;
         applied_count_ff   <= '0;
      end else begin
         header_index_ff    <= header_index_in;
         record_address_ff  <= record_address_in;
         record_length_ff   <= record_length_in;
         payload_left_ff    <= payload_left_in;
         stream_position_ff <= stream_position_in;
         write_pointer_ff   <= write_pointer_in;
         payload_mode_ff    <= payload_mode_in;
         stopped_ff         <= stopped_in;
         applied_count_ff   <= applied_count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/prc_output_stage.sv]
`default_nettype none

module prc_output_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic               res_valid,
   input  wire prc_pkg::prc_result_type res,
   output logic                    can_accept,
   prc_result_chan.source          rsp_if
);
   import prc_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   prc_result_type data_ff;
   logic           load;

   assign can_accept = !valid_ff || rsp_if.ready;
   assign load = fire && res_valid;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.result_kind   = data_ff.result_kind;
   assign rsp_if.target        = data_ff.target;
   assign rsp_if.data_byte     = data_ff.data_byte;
   assign rsp_if.report_code   = data_ff.report_code;
   assign rsp_if.block_length  = data_ff.block_length;
   assign rsp_if.applied_total = data_ff.applied_total;

endmodule

`default_nettype wire

[hdl/prc_checker.sv]
`default_nettype none
`include "patch_record_applier_macros.svh"

module prc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [31:0] rsp_target,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic [2:0]  rsp_report_code,
   input wire logic [30:0] rsp_block_length,
   input wire logic [31:0] rsp_applied_total
);
   import prc_pkg::*;

   logic stop_taken;
   logic write_item;

   assign stop_taken = rsp_valid && rsp_ready && (rsp_result_kind == KIND_REPORT) &&
                       ((rsp_report_code == RPT_END) || (rsp_report_code == RPT_OVERRUN));
   assign write_item = rsp_valid && (rsp_result_kind != KIND_REPORT);

   // A stalled result keeps all of its fields.
   `PRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_target) && $stable(rsp_data_byte) && $stable(rsp_report_code) && $stable(rsp_block_length) && $stable(rsp_applied_total))

   // Once an end or overrun report is taken, the stream is finished.
   `PRC_ASSERT_NEXT(a_stop_final, clock, reset, stop_taken, !rsp_valid)

   // Byte writes and deferred bytes carry the RPT_APPLIED code and no block length.
   `PRC_ASSERT_NOW(a_write_fields, clock, reset, write_item, (rsp_report_code == RPT_APPLIED) && (rsp_block_length == 31'd0))

   `PRC_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind patch_record_applier prc_checker u_prc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_result_kind   (rsp_if.result_kind),
   .rsp_target        (rsp_if.target),
   .rsp_data_byte     (rsp_if.data_byte),
   .rsp_report_code   (rsp_if.report_code),
   .rsp_block_length  (rsp_if.block_length),
   .rsp_applied_total (rsp_if.applied_total)
);

`default_nettype wire

[tb/tb_patch_record_applier.sv]
module tb_patch_record_applier;
   import prc_pkg::*;

   localparam int          SETTLE_CYCLES    = 8;
   localparam int          LONG_HOLD_CYCLES = 200;
   localparam int          PHASE_BYTES      = 32;
   localparam logic [2:0]  CSR_FIRST_UNUSED = 3'd5;

   // Mirror of the applier: follows every accepted byte and keeps the results it
   // must produce, oldest first.
   class patch_scoreboard;
      prc_cfg_type    cfg;
      logic [2:0]     hdr_idx;
      logic [31:0]    rec_addr;
      logic [31:0]    rec_len_word;
      logic [30:0]    left;
      logic [31:0]    pos;
      logic [31:0]    wptr;
      prc_mode_type   mode;
      bit             halted;
      logic [31:0]    applied;
      prc_result_type due[$];
      int             errors;

      function new();
         cfg = '0;
         hdr_idx = '0;
         rec_addr = '0;
         rec_len_word = '0;
         left = '0;
         pos = '0;
         wptr = '0;
         mode = MODE_SKIP;
         halted = 1'b0;
         applied = '0;
         errors = 0;
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [31:0] val);
         case (idx)
            CSR_OVERLAY_PRESENT:  cfg.overlay_present = val[0];
            CSR_OVERLAY_BASE:     cfg.overlay_base = val;
            CSR_OVERLAY_CODE_END: cfg.overlay_code_end = val;
            CSR_IMAGE_SIZE:       cfg.image_size = val;
            CSR_PATCH_SIZE:       cfg.patch_size = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void add_due(input prc_result_type r);
         due = {due, r};
      endfunction

      function void push_report(input prc_code_type code, input logic [30:0] len);
         prc_result_type r;
         r.result_kind = KIND_REPORT;
         r.target = rec_addr;
         r.data_byte = '0;
         r.report_code = code;
         r.block_length = len;
         r.applied_total = applied;
         add_due(r);
      endfunction

      function void note_byte(input logic [7:0] b);
         prc_result_type r;
         logic [30:0]    len;
         logic [31:0]    guest;
         logic           in_ram;
         if (halted || pos >= cfg.patch_size) return;
         pos = pos + 1;
         if (left != 0) begin
            left = left - 1;
            if (mode != MODE_SKIP) begin
               if (mode == MODE_IMAGE) begin
                  r.result_kind = KIND_WRITE;
               end else begin
                  r.result_kind = KIND_DEFER;
               end
               r.target = wptr;
               r.data_byte = b;
               r.report_code = RPT_APPLIED;
               r.block_length = '0;
               r.applied_total = applied;
               add_due(r);
            end
            wptr = wptr + 1;
            if (left == 0) mode = MODE_SKIP;
            return;
         end

         if (hdr_idx < 4) begin
            rec_addr[8*hdr_idx +: 8] = b;
         end else begin
            rec_len_word[8*(hdr_idx-4) +: 8] = b;
         end
         if (hdr_idx != HEADER_LAST) begin
            hdr_idx = hdr_idx + 1;
            return;
         end
         hdr_idx = '0;

         len = rec_len_word[30:0];
         if (rec_addr == END_MARKER) begin
            halted = 1'b1;
            push_report(RPT_END, len);
            return;
         end
         if ({1'b0, pos} + {2'b0, len} > {1'b0, cfg.patch_size}) begin
            halted = 1'b1;
            push_report(RPT_OVERRUN, len);
            return;
         end
         left = len;
         mode = MODE_SKIP;
         if (rec_len_word[LOAD_CODE_BIT]) begin
            push_report(RPT_LOAD_CODE, len);
            return;
         end
         guest = rec_addr & MIRROR_MASK;
         in_ram = (guest >= RAM_START) && (guest < RAM_END);
         if (cfg.overlay_present && in_ram && guest >= cfg.overlay_base &&
             {1'b0, guest - cfg.overlay_base} + {2'b0, len} <= {1'b0, cfg.image_size}) begin
            mode = MODE_IMAGE;
            wptr = guest - cfg.overlay_base;
            applied = applied + 1;
            if (guest < cfg.overlay_code_end) begin
               push_report(RPT_CHANGES_CODE, len);
            end else begin
               push_report(RPT_APPLIED, len);
            end
         end else if (cfg.overlay_present && in_ram) begin
            mode = MODE_DEFER;
            wptr = guest;
            push_report(RPT_DEFERRED, len);
         end else if (!in_ram && {1'b0, rec_addr} + {2'b0, len} <= {1'b0, cfg.image_size}) begin
            mode = MODE_IMAGE;
            wptr = rec_addr;
            applied = applied + 1;
            push_report(RPT_APPLIED, len);
         end else if (in_ram) begin
            push_report(RPT_NEEDS_FIXED, len);
         end else begin
            push_report(RPT_OUTSIDE, len);
         end
         if (left == 0) mode = MODE_SKIP;
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] seen);
         if (seen !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
         end
      endfunction

      function void check_result(input logic [1:0] kind, input logic [31:0] target,
                                 input logic [7:0] data, input logic [2:0] code,
                                 input logic [30:0] len, input logic [31:0] total);
         prc_result_type want;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %h target %h data %h",
                     $time, kind, target, data);
            return;
         end
         want = due.pop_front();
         compare_field("result_kind", want.result_kind, kind);
         compare_field("target", want.target, target);
         compare_field("data_byte", want.data_byte, data);
         compare_field("report_code", want.report_code, code);
         compare_field("block_length", want.block_length, len);
         compare_field("applied_total", want.applied_total, total);
      endfunction
   endclass

   logic clock;
   logic reset;

   prc_byte_chan   req_ch();
   prc_result_chan rsp_ch();
   prc_csr_chan    csr_ch();

   patch_record_applier u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   patch_scoreboard sb;
   prc_cfg_type     cur;
   prc_cfg_type     next_cfg;
   int              req_idle_odds = 0;
   int              rsp_idle_odds = 0;
   bit              long_hold_armed = 1'b0;
   int              bytes_sent = 0;
   int              phase_start;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_byte(req_ch.patch_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.result_kind, rsp_ch.target, rsp_ch.data_byte,
                            rsp_ch.report_code, rsp_ch.block_length, rsp_ch.applied_total);
         end
      end
   end

   // Result side: random stalls, plus one long hold-off that lets the block fill up.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idle_odds != 0 && $urandom_range(0, 99) < rsp_idle_odds) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic push_byte(input logic [7:0] b);
      if (req_idle_odds != 0 && $urandom_range(0, 99) < req_idle_odds) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.patch_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [31:0] addr, input logic [31:0] len_word);
      for (int i = 0; i < 4; i++) push_byte(addr[8*i +: 8]);
      for (int i = 0; i < 4; i++) push_byte(len_word[8*i +: 8]);
   endtask

   task automatic send_record(input logic [31:0] addr, input logic [31:0] len_word);
      send_header(addr, len_word);
      for (int i = 0; i < len_word[30:0]; i++) push_byte(8'($urandom()));
   endtask

   // Waits until every expected result has come out and the pipeline is empty.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic load_config(input prc_cfg_type c);
      logic [2:0] spare_idx;
      spare_idx = CSR_FIRST_UNUSED + 3'($urandom_range(0, 2));
      write_reg(CSR_OVERLAY_PRESENT, ($urandom() & 32'hFFFF_FFFE) | {31'b0, c.overlay_present});
      write_reg(CSR_OVERLAY_BASE, c.overlay_base);
      write_reg(CSR_OVERLAY_CODE_END, c.overlay_code_end);
      write_reg(CSR_IMAGE_SIZE, c.image_size);
      write_reg(CSR_PATCH_SIZE, c.patch_size);
      write_reg(spare_idx, $urandom());
      csr_ch.valid <= 1'b0;
      cur = c;
   endtask

   // Zero-filled bytes finish any header or payload left open, so the next
   // record starts on a header boundary. Only called while the block is idle.
   task automatic realign();
      int n;
      n = sb.left + ((sb.hdr_idx != 0) ? 8 - sb.hdr_idx : 0);
      repeat (n) push_byte(8'h00);
   endtask

   task automatic random_record();
      logic [31:0] addr;
      logic [31:0] len_word;
      logic [1:0]  mirror;
      int          sel;
      mirror = 2'($urandom());
      len_word = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: addr = {mirror, 30'(cur.overlay_base + $urandom_range(0, 72))};
         2: addr = {mirror, 30'(RAM_START + $urandom_range(0, 32'h03FF_FFFF))};
         3: addr = {mirror, 30'(cur.overlay_code_end + $urandom_range(0, 8) - 32'd4)};
         4: addr = {mirror, 30'((($urandom_range(0, 1) != 0) ? RAM_END : RAM_START) -
                               $urandom_range(0, 1))};
         5: addr = $urandom();
         6: begin
            addr = {mirror, 30'(RAM_START + $urandom_range(0, 32'h03FF_FFFF))};
            len_word[LOAD_CODE_BIT] = 1'b1;
         end
         7: addr = cur.image_size - len_word[30:0] + $urandom_range(0, 2) - 32'd1;
         default: addr = $urandom_range(0, 80);
      endcase
      if ($urandom_range(0, 9) == 0) len_word[LOAD_CODE_BIT] = 1'b1;
      // The end marker would stop the block for good, so it waits for the end.
      if (addr == END_MARKER) addr[0] = 1'b0;
      send_record(addr, len_word);
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.patch_byte <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      cur = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Patch size is zero after reset, so every byte is dropped.
      push_byte(8'h00);
      push_byte(8'hFF);
      repeat (4) push_byte(8'($urandom()));
      drain();

      next_cfg = '{1'b1, 32'h0810_0000, 32'h0810_0010, 32'h0000_0040, 32'hFFFF_FFFF};
      load_config(next_cfg);
      send_record(32'h0810_0000, 32'd4);
      send_record(32'h4810_0020, 32'd3);
      send_record(32'hC810_0038, 32'd8);
      send_record(32'h0810_0039, 32'd8);
      send_record(32'h0800_0000, 32'd2);
      send_record(32'h0810_0000, 32'h8000_0003);
      send_record(32'h0810_0004, 32'd0);
      send_record(32'h0000_0010, 32'd4);
      send_record(32'h0000_003E, 32'd4);
      send_record(32'h0C00_0000, 32'd0);
      send_record(32'h0BFF_FFFF, 32'd1);
      drain();

      next_cfg = '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      load_config(next_cfg);
      send_record(32'h0800_0000, 32'd2);
      send_record(32'hFFFF_FFF0, 32'd15);
      send_record(32'hFFFF_FFF0, 32'd16);
      send_record(32'h07FF_FFFF, 32'd1);
      drain();

      // The patch ends just after the next record plus three header bytes: the
      // record fits and the partial header after it is cut off.
      next_cfg.patch_size = sb.pos + 32'd14;
      load_config(next_cfg);
      send_record(32'h0000_0020, 32'd3);
      repeat (8) push_byte(8'($urandom()));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         next_cfg.overlay_present = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom());
         next_cfg.overlay_base = RAM_START + $urandom_range(0, 32'h03FF_FF00);
         next_cfg.overlay_code_end = next_cfg.overlay_base + $urandom_range(0, 40);
         next_cfg.image_size = $urandom_range(0, 96);
         next_cfg.patch_size = 32'hFFFF_FFFF;
         case (phase)
            1: begin
               next_cfg.overlay_base = 32'h0000_0000;
               next_cfg.overlay_code_end = 32'hFFFF_FFFF;
               next_cfg.image_size = 32'hFFFF_FFFF;
            end
            3: begin
               next_cfg.overlay_base = 32'hFFFF_FFFF;
               next_cfg.overlay_code_end = 32'h0000_0000;
               next_cfg.image_size = 32'h0000_0000;
            end
            4: next_cfg.patch_size = sb.pos + 32'h0001_0000;
            default: ;
         endcase
         load_config(next_cfg);
         realign();
         if (phase == 5) begin
            req_idle_odds = 0;
            rsp_idle_odds = 0;
         end else begin
            req_idle_odds = (phase == 1) ? 0 : $urandom_range(2, 20);
            rsp_idle_odds = (phase == 3) ? 0 : $urandom_range(1, 8);
         end
         if (phase == 2) long_hold_armed = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) random_record();
         drain();
      end

      // One record that stops the block; it stays stopped for the rest of the run.
      case ($urandom_range(0, 2))
         0: send_header(END_MARKER, $urandom_range(0, 12));
         1: begin
            next_cfg.patch_size = sb.pos + 32'd8 + 32'h7FFF_FFFE;
            load_config(next_cfg);
            send_header(32'h0000_0020, 32'h7FFF_FFFF);
         end
         default: begin
            // End marker whose length would also overrun: the end marker wins.
            next_cfg.patch_size = sb.pos + 32'd12;
            load_config(next_cfg);
            send_header(END_MARKER, 32'hFFFF_FFFF);
         end
      endcase
      send_record(32'h0000_0010, 32'd2);
      repeat (6) push_byte(8'($urandom()));
      drain();

      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
